### src/mrul_pkg.sv
// Shared types and constants for the move-to-front MRU list.
// Used by mrul_match, mrul_list and mru_list_move_to_front_unit; no dependencies.
`timescale 1ns / 1ps

package mrul_pkg;

  // List geometry
  localparam int DEPTH = 16;
  localparam int ID_W  = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [ID_W-1:0]  ident_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Item kinds
  typedef enum logic {
    KIND_TOUCH = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  // Position code for a new or ignored identifier
  localparam cnt_t POS_NONE = cnt_t'(DEPTH);

  // One input item
  typedef struct packed {
    kind_t  kind;
    ident_t ident;
    idx_t   index;
  } cmd_t;

  // One result item
  typedef struct packed {
    ident_t entry_ident;
    logic   entry_valid;
    cnt_t   list_count;
    cnt_t   prior_position;
  } result_t;

  // Outcome of the associative search
  typedef struct packed {
    logic hit;
    idx_t pos;
  } match_t;

endpackage

### src/mrul_match.sv
// Associative search of the MRU list: one comparator per slot and a priority encoder.
// Depends on mrul_pkg.
`timescale 1ns / 1ps

module mrul_match
  import mrul_pkg::*;
(
  input  ident_t entries [DEPTH],
  input  cnt_t   count,
  input  ident_t ident,
  output match_t match
);

  logic [DEPTH-1:0] eq;

  // Compare every occupied slot against the identifier
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      eq[i] = (cnt_t'(i) < count) && (entries[i] == ident);
    end
  end

  // Pick the lowest matching position
  always_comb begin
    match.hit = |eq;
    match.pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (eq[i]) begin
        match.pos = idx_t'(i);
      end
    end
  end

endmodule

### src/mrul_list.sv
// MRU list storage, count register and the single-pass touch/read update.
// Depends on mrul_pkg and mrul_match.
`timescale 1ns / 1ps

module mrul_list
  import mrul_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  cmd_t    cmd,
  output result_t res
);

  ident_t entries_r   [DEPTH];
  ident_t entries_nxt [DEPTH];
  cnt_t   count_r;
  cnt_t   count_nxt;
  match_t match;
  idx_t   shift_lim;
  logic   do_touch;

  mrul_match u_match (
    .entries (entries_r),
    .count   (count_r),
    .ident   (cmd.ident),
    .match   (match)
  );

  assign do_touch = (cmd.kind == KIND_TOUCH) && (cmd.ident != '0);

  // A hit shifts only the slots ahead of it; a miss shifts the whole list
  assign shift_lim = match.hit ? match.pos : idx_t'(DEPTH - 1);

  // Build the next list contents and count
  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < DEPTH; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    if (do_touch) begin
      entries_nxt[0] = cmd.ident;
      for (int i = 1; i < DEPTH; i++) begin
        if (idx_t'(i) <= shift_lim) begin
          entries_nxt[i] = entries_r[i-1];
        end
      end
      if (!match.hit && (count_r < cnt_t'(DEPTH))) begin
        count_nxt = count_r + cnt_t'(1);
      end
    end
  end

  // Form the result item
  always_comb begin
    res.entry_ident    = '0;
    res.entry_valid    = 1'b0;
    res.list_count     = count_nxt;
    res.prior_position = POS_NONE;
    if (cmd.kind == KIND_READ) begin
      if (cnt_t'(cmd.index) < count_r) begin
        res.entry_ident = entries_r[cmd.index];
        res.entry_valid = 1'b1;
      end
    end else if (do_touch && match.hit) begin
      res.prior_position = cnt_t'(match.pos);
    end
  end

  // Hold the count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (en) begin
      count_r <= count_nxt;
    end
  end

  // Hold the entries; slots past the count are never read
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
    end
  end

endmodule

### src/mru_list_move_to_front_unit.sv
// Top level of the move-to-front MRU list: input register, list update, result register.
// Depends on mrul_pkg and mrul_list.
//
//   channel | ports                                                  | direction
//   --------+--------------------------------------------------------+----------
//   input   | in_valid, in_stall, in_kind, in_ident, in_index        | in
//   result  | out_valid, out_stall, out_entry_ident, out_entry_valid,| out
//           | out_list_count, out_prior_position                     |
//
// One item per clock sustained while the result side does not stall; each item is held
// in the input register, where the comparators, priority encoder and shift mux update
// the list, then sits in the result register. out_valid rises at the edge on which the
// item moves from the input register into the result register.
// Synchronous active-low reset clears the count and both valid flags.
// A stall on the result side holds the result register and then the input register.
`timescale 1ns / 1ps

module mru_list_move_to_front_unit
  import mrul_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  logic   in_kind,
  input  ident_t in_ident,
  input  idx_t   in_index,
  output logic   out_valid,
  input  logic   out_stall,
  output ident_t out_entry_ident,
  output logic   out_entry_valid,
  output cnt_t   out_list_count,
  output cnt_t   out_prior_position
);

  logic    s1_valid_r;
  cmd_t    s1_cmd_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    adv;
  logic    in_accept;

  // Move the held item on when the result register is free or being emptied
  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign in_accept = in_valid && !in_stall;

  mrul_list u_list (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .cmd   (s1_cmd_r),
    .res   (res)
  );

  // Input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r.kind  <= kind_t'(in_kind);
      s1_cmd_r.ident <= in_ident;
      s1_cmd_r.index <= in_index;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_entry_ident    = out_res_r.entry_ident;
  assign out_entry_valid    = out_res_r.entry_valid;
  assign out_list_count     = out_res_r.list_count;
  assign out_prior_position = out_res_r.prior_position;

endmodule
